### design/dip_pkg.sv
// Package for the decimal integer parser: character codes, phase encoding,
// and the structs passed between the input stage and the parse core.
// No dependencies.
`timescale 1ns / 1ps

package dip_pkg;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  // Counter limits and register reset
  localparam logic [4:0] DIGIT_SAT      = 5'd31;
  localparam logic [7:0] BYTE_SAT       = 8'd255;
  localparam logic [4:0] MAX_DIGITS_RST = 5'd19;

  // Parse phase; codes 2 and 3 behave as PH_NUM
  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_NUM  = 2'd1
  } phase_t;

  // Registered input byte handed to the core
  typedef struct packed {
    logic       valid;
    logic [7:0] char_byte;
  } stage_t;

  // One parse result
  typedef struct packed {
    logic signed [63:0] value;
    logic [7:0]         consumed_len;
    logic               no_digits;
    logic               too_long;
  } result_t;

endpackage

### design/dip_in_if.sv
// Input channel of the decimal integer parser: one ASCII byte per item.
// No dependencies.
`timescale 1ns / 1ps

interface dip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

### design/dip_out_if.sv
// Result channel of the decimal integer parser: one parsed number per item.
// No dependencies.
`timescale 1ns / 1ps

interface dip_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic [7:0]         consumed_len;
  logic               no_digits;
  logic               too_long;

  modport source (output valid, output value, output consumed_len,
                  output no_digits, output too_long, input ready);
  modport sink   (input valid, input value, input consumed_len,
                  input no_digits, input too_long, output ready);
endinterface

### design/dip_in_reg.sv
// Input register stage of the decimal integer parser.
// Depends on dip_pkg.
`timescale 1ns / 1ps

module dip_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_char_byte,
  output logic            in_ready,
  input  logic            consume,
  output dip_pkg::stage_t stage
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  // Take a new item when the stage is empty or its item leaves this cycle
  assign in_ready = !valid_r || consume;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the byte until it is consumed
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_char_byte;
    end
  end

  assign stage.valid     = valid_r;
  assign stage.char_byte = byte_r;

endmodule

### design/dip_core.sv
// Parse core: per-number state, one step per byte, and the result register.
// Depends on dip_pkg.
`timescale 1ns / 1ps

module dip_core (
  input  logic             clk,
  input  logic             rst_n,
  input  dip_pkg::stage_t  stage,
  input  logic [4:0]       max_digits,
  input  logic             out_ready,
  output logic             consume,
  output logic             out_valid,
  output dip_pkg::result_t result
);

  dip_pkg::phase_t  phase_r, phase_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic             neg_r, neg_nxt;
  logic [4:0]       dcnt_r, dcnt_nxt;
  logic [7:0]       bcnt_r, bcnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  dip_pkg::result_t res_r, res_nxt;

  logic [7:0]  c;
  logic        is_digit;
  logic        is_ws;
  logic        is_sign;
  logic        skipping;
  logic        take_ws;
  logic        take_sign;
  logic        is_term;
  logic        slot_free;
  logic        emit;
  logic [63:0] acc_step;
  logic [7:0]  bcnt_inc;

  // Classify the byte
  assign c        = stage.char_byte;
  assign is_digit = (c >= dip_pkg::CH_ZERO) && (c <= dip_pkg::CH_NINE);
  assign is_ws    = (c == dip_pkg::CH_SPACE) || (c == dip_pkg::CH_TAB);
  assign is_sign  = (c == dip_pkg::CH_MINUS) || (c == dip_pkg::CH_PLUS);
  assign skipping = (phase_r == dip_pkg::PH_SKIP);
  assign take_ws   = skipping && is_ws;
  assign take_sign = skipping && is_sign;
  assign is_term   = !(take_ws || take_sign || is_digit);

  // A terminator needs a free result slot; other bytes always advance
  assign slot_free = !out_valid_r || out_ready;
  assign consume   = stage.valid && (!is_term || slot_free);
  assign emit      = consume && is_term;

  // acc * 10 + digit as two shifts and two adds
  assign acc_step = {acc_r[60:0], 3'b000} + {acc_r[62:0], 1'b0}
                  + {60'd0, 4'(c - dip_pkg::CH_ZERO)};
  assign bcnt_inc = (bcnt_r == dip_pkg::BYTE_SAT) ? bcnt_r : bcnt_r + 8'd1;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (consume) begin
      priority if (take_ws) begin
        phase_nxt = phase_r;
      end else if (take_sign || is_digit) begin
        phase_nxt = dip_pkg::PH_NUM;
      end else begin
        phase_nxt = dip_pkg::PH_SKIP;
      end
    end
  end

  // Number state: accumulate, count, or clear on the terminator
  always_comb begin
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    dcnt_nxt = dcnt_r;
    bcnt_nxt = bcnt_r;
    if (consume) begin
      priority if (take_ws) begin
        bcnt_nxt = bcnt_inc;
      end else if (take_sign) begin
        neg_nxt  = (c == dip_pkg::CH_MINUS);
        bcnt_nxt = bcnt_inc;
      end else if (is_digit) begin
        acc_nxt  = acc_step;
        dcnt_nxt = (dcnt_r == dip_pkg::DIGIT_SAT) ? dcnt_r : dcnt_r + 5'd1;
        bcnt_nxt = bcnt_inc;
      end else begin
        acc_nxt  = '0;
        neg_nxt  = 1'b0;
        dcnt_nxt = '0;
        bcnt_nxt = '0;
      end
    end
  end

  // Result register: load on the terminator, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (emit) begin
      out_valid_nxt        = 1'b1;
      res_nxt.value        = neg_r ? $signed(64'd0 - acc_r) : $signed(acc_r);
      res_nxt.consumed_len = bcnt_r;
      res_nxt.no_digits    = (dcnt_r == 5'd0);
      res_nxt.too_long     = (dcnt_r > max_digits);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dip_pkg::PH_SKIP;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      dcnt_r      <= '0;
      bcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      dcnt_r      <= dcnt_nxt;
      bcnt_r      <= bcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

`ifndef NO_ASSERTIONS
  // A terminator leaves the number state cleared
  a_clear_after_term: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (acc_r == 64'd0) && (dcnt_r == 5'd0) && (bcnt_r == 8'd0)
             && (phase_r == dip_pkg::PH_SKIP) && !neg_r)
    else $error("number state not cleared after terminator");

  // Without digits the accumulator stays zero
  a_acc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (dcnt_r == 5'd0) |-> (acc_r == 64'd0))
    else $error("accumulator nonzero with no digits");

  // Every digit is also a counted byte
  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r >= {3'd0, dcnt_r})
    else $error("byte count below digit count");

  // A result without digits carries value zero
  a_no_digits_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.no_digits) |-> (res_r.value == 64'sd0))
    else $error("no_digits result with nonzero value");
`endif

endmodule

### design/decimal_integer_parser.sv
// Decimal integer parser top level: input register, parse core, max_digits.
// An accepted byte is held in the input register and stepped by the core; a
// terminator loads the result register. One byte per cycle, unless a
// terminator waits for a free result slot. Reset (rst_n, synchronous, active
// low) clears the phase, counters, accumulator, both valid flags and sets
// max_digits to 19. Depends on dip_pkg, dip_in_if, dip_out_if and submodules.
`timescale 1ns / 1ps

module decimal_integer_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [4:0]       cfg_wr_data,
  dip_in_if.sink           in_chan,
  dip_out_if.source        out_chan
);

  logic [4:0]       max_digits_r;
  dip_pkg::stage_t  stage;
  logic             consume;
  logic             out_valid;
  dip_pkg::result_t result;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_digits_r <= dip_pkg::MAX_DIGITS_RST;
    end else if (cfg_wr_en) begin
      max_digits_r <= cfg_wr_data;
    end
  end

  dip_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_char_byte (in_chan.char_byte),
    .in_ready     (in_chan.ready),
    .consume      (consume),
    .stage        (stage)
  );

  dip_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage      (stage),
    .max_digits (max_digits_r),
    .out_ready  (out_chan.ready),
    .consume    (consume),
    .out_valid  (out_valid),
    .result     (result)
  );

  // Drive the result channel
  assign out_chan.valid        = out_valid;
  assign out_chan.value        = result.value;
  assign out_chan.consumed_len = result.consumed_len;
  assign out_chan.no_digits    = result.no_digits;
  assign out_chan.too_long     = result.too_long;

endmodule

### tb/dip_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the decimal integer parser: watches both channels and the
// max_digits write port, predicts each parsed number and checks every result.
// Depends on dip_pkg, dip_in_if and dip_out_if.

module dip_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  dip_in_if          byte_mon,
  dip_out_if         num_mon,
  output int         fail_count,
  output int         open_numbers,
  output int         numbers_done,
  output int         too_long_seen,
  output int         empty_seen
);

  // Parser state mirrored from the accepted byte stream
  dip_pkg::phase_t parse_phase;
  logic [63:0]     acc;
  logic            is_neg;
  logic [4:0]      digit_cnt;
  logic [7:0]      len_cnt;
  logic [4:0]      digit_limit;

  // Numbers predicted but not yet seen on the result channel
  dip_pkg::result_t pending_numbers[$];

  int errors;
  int done;
  int n_long;
  int n_empty;

  // Drop the number in progress and go back to skipping whitespace
  task clear_number();
    parse_phase = dip_pkg::PH_SKIP;
    acc         = '0;
    is_neg      = 1'b0;
    digit_cnt   = '0;
    len_cnt     = '0;
  endtask

  // Advance the parser by one byte; queue a number when the byte ends one
  task parse_char(input logic [7:0] c);
    logic             skipping;
    logic             ends;
    dip_pkg::result_t num;
    skipping = (parse_phase == dip_pkg::PH_SKIP);
    ends     = 1'b0;
    if (skipping && (c == dip_pkg::CH_MINUS || c == dip_pkg::CH_PLUS)) begin
      is_neg      = (c == dip_pkg::CH_MINUS);
      parse_phase = dip_pkg::PH_NUM;
    end else if (c >= dip_pkg::CH_ZERO && c <= dip_pkg::CH_NINE) begin
      acc = acc * 64'd10 + 64'(c - dip_pkg::CH_ZERO);
      if (digit_cnt != dip_pkg::DIGIT_SAT) digit_cnt = digit_cnt + 5'd1;
      parse_phase = dip_pkg::PH_NUM;
    end else if (!(skipping && (c == dip_pkg::CH_SPACE || c == dip_pkg::CH_TAB))) begin
      // whitespace after a sign or digit, a sign after a sign or digit, or any other byte
      ends = 1'b1;
    end

    if (ends) begin
      num.value        = is_neg ? (64'd0 - acc) : acc;
      num.consumed_len = len_cnt;
      num.no_digits    = (digit_cnt == 5'd0);
      num.too_long     = (digit_cnt > digit_limit);
      pending_numbers.push_back(num);
      clear_number();
    end else if (len_cnt != dip_pkg::BYTE_SAT) begin
      len_cnt = len_cnt + 8'd1;
    end
  endtask

  // Sample at the clock edge: register write, byte in, number out
  always @(posedge clk) begin : track
    dip_pkg::result_t want;
    if (!rst_n) begin
      clear_number();
      digit_limit = dip_pkg::MAX_DIGITS_RST;
      pending_numbers.delete();
    end else begin
      if (cfg_wr_en) digit_limit = cfg_wr_data;
      if (byte_mon.valid && byte_mon.ready) parse_char(byte_mon.char_byte);
      if (num_mon.valid && num_mon.ready) begin
        if (pending_numbers.size() == 0) begin
          $error("number out with none pending: value %0d", num_mon.value);
          errors++;
        end else begin
          want = pending_numbers.pop_front();
          done++;
          if (want.too_long) n_long++;
          if (want.no_digits) n_empty++;
          if (num_mon.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, num_mon.value);
            errors++;
          end
          if (num_mon.consumed_len !== want.consumed_len) begin
            $error("consumed_len: expected %0d, got %0d",
                   want.consumed_len, num_mon.consumed_len);
            errors++;
          end
          if (num_mon.no_digits !== want.no_digits) begin
            $error("no_digits: expected %0b, got %0b", want.no_digits, num_mon.no_digits);
            errors++;
          end
          if (num_mon.too_long !== want.too_long) begin
            $error("too_long: expected %0b, got %0b", want.too_long, num_mon.too_long);
            errors++;
          end
        end
      end
    end
    fail_count    <= errors;
    open_numbers  <= pending_numbers.size();
    numbers_done  <= done;
    too_long_seen <= n_long;
    empty_seen    <= n_empty;
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the decimal integer parser bench: clock, reset, byte stream, result
// back-pressure and max_digits settings; the verdict comes from dip_checker.
// Depends on dip_pkg, dip_in_if, dip_out_if, decimal_integer_parser, dip_checker.

module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 6;
  localparam int PHASE_BYTES = 110;
  localparam int OUT_HOLD    = 300;
  localparam int HOLD_AFTER  = 40;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [4:0] cfg_wr_data;

  dip_in_if  byte_if ();
  dip_out_if num_if ();

  int fail_count;
  int open_numbers;
  int numbers_done;
  int too_long_seen;
  int empty_seen;
  int cycle_count = 0;
  int bytes_sent  = 0;
  int settings_used = 1;
  bit in_quiet;

  decimal_integer_parser dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (byte_if),
    .out_chan    (num_if)
  );

  dip_checker num_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .byte_mon      (byte_if),
    .num_mon       (num_if),
    .fail_count    (fail_count),
    .open_numbers  (open_numbers),
    .numbers_done  (numbers_done),
    .too_long_seen (too_long_seen),
    .empty_seen    (empty_seen)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Offer one byte after a random gap and hold it until accepted
  task send_byte(input logic [7:0] c);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_if.valid     <= 1'b1;
    byte_if.char_byte <= c;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // One number: leading whitespace, optional sign, digits, a terminator
  task send_token(input int n_ws);
    int         sign_pick;
    int         n_dig;
    int         term_pick;
    logic [7:0] term;
    repeat (n_ws) send_byte($urandom_range(0, 1) ? dip_pkg::CH_SPACE : dip_pkg::CH_TAB);
    sign_pick = $urandom_range(0, 3);
    if (sign_pick == 1) send_byte(dip_pkg::CH_PLUS);
    else if (sign_pick == 2) send_byte(dip_pkg::CH_MINUS);
    // mostly short numbers, now and then past 64-bit range and digit saturation
    n_dig = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 6);
    repeat (n_dig) send_byte(dip_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    term_pick = $urandom_range(0, 9);
    if (term_pick < 4) begin
      term = $urandom_range(0, 1) ? dip_pkg::CH_SPACE : dip_pkg::CH_TAB;
    end else if (term_pick == 4) begin
      term = $urandom_range(0, 1) ? dip_pkg::CH_PLUS : dip_pkg::CH_MINUS;
    end else begin
      term = 8'($urandom_range(0, 255));
      while (term >= dip_pkg::CH_ZERO && term <= dip_pkg::CH_NINE) begin
        term = 8'($urandom_range(0, 255));
      end
    end
    send_byte(term);
  endtask

  // Drop valid, wait for every predicted number, then let the pipe settle
  task wait_drained();
    byte_if.valid <= 1'b0;
    @(posedge clk);
    while (open_numbers != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task set_max_digits(input logic [4:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    settings_used++;
  endtask

  // Stimulus: reset, directed bytes, then random phases per max_digits value
  initial begin : stimulus
    logic [4:0] limits [8];
    int         start;
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    byte_if.valid     <= 1'b0;
    byte_if.char_byte <= '0;
    in_quiet = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: whitespace, signs, digit bounds and each kind of terminator
    send_text(" \t-7 ");
    send_text("+-");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("09:");
    send_text("/");
    send_text("+12-");
    send_text("-0\t");
    send_text("5\n");

    limits = '{5'd1, 5'd0, 5'd31, 5'd30, 5'd20, 5'd19, 5'd0, 5'd0};
    limits[6] = 5'($urandom_range(0, 31));
    limits[7] = 5'($urandom_range(0, 31));
    foreach (limits[i]) begin
      set_max_digits(limits[i]);
      start = bytes_sent;
      // saturate the byte counter once with a long run of whitespace
      if (i == 2) send_token(300);
      while (bytes_sent - start < PHASE_BYTES) begin
        in_quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end else begin
          send_token(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        end
      end
    end

    wait_drained();
    $display("Checked %0d numbers (%0d too long, %0d without digits) from %0d bytes",
             numbers_done, too_long_seen, empty_seen, bytes_sent);
    $display("under %0d max_digits settings, with one %0d-cycle result stall",
             settings_used, OUT_HOLD);
    if (fail_count == 0 && open_numbers == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side: random stalls, quiet stretches, and one long hold-off
  initial begin : receiver
    int gap;
    int got;
    bit quiet;
    bit held;
    got   = 0;
    quiet = 1'b0;
    held  = 1'b0;
    num_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && got >= HOLD_AFTER) begin
        held = 1'b1;
        num_if.ready <= 1'b0;
        repeat (OUT_HOLD) @(posedge clk);
      end
      gap = quiet ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        num_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      num_if.ready <= 1'b1;
      @(posedge clk);
      while (!num_if.valid) @(posedge clk);
      got++;
      if (got % 50 == 0) quiet = ($urandom_range(0, 2) == 0);
    end
  end

  // Bail out if the run hangs
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

endmodule
